/* rtl/wbcs_pkg.sv */
// ----------------------------------------------------------------------------
// wbcs_pkg
// Shared types, codes and helpers of the window base count signature block.
// ----------------------------------------------------------------------------
`default_nettype none

package wbcs_pkg;

	localparam int MAX_WINDOW_DEF = 254;
	localparam int HIST_DEPTH     = 255;
	localparam int NUM_TABLES     = 4;
	localparam int STORE_PORTS    = 5;
	localparam logic [31:0] TAINT_SIG = 32'hFFFF_FF00;
	localparam logic [31:0] SAT32     = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		REG_BASE1 = 3'd0,
		REG_BASE2 = 3'd1,
		REG_BASE3 = 3'd2,
		REG_BASE4 = 3'd3,
		REG_WLEN  = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ACT_PUSH    = 2'd0,
		ACT_HIST    = 2'd1,
		ACT_SUM     = 2'd2,
		ACT_RESTART = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		CL_B1    = 3'd0,
		CL_B2    = 3'd1,
		CL_B3    = 3'd2,
		CL_B4    = 3'd3,
		CL_OTHER = 3'd4
	} class_t;

	typedef struct packed {
		logic [7:0] base1;
		logic [7:0] base2;
		logic [7:0] base3;
		logic [7:0] base4;
		logic [7:0] wlen;
	} cfg_t;

	// window stage to statistics stage
	typedef struct packed {
		logic                        valid;
		action_t                     action;
		logic [1:0]                  sel;
		logic [7:0]                  idx;
		logic                        emit;
		logic                        upd;
		logic [NUM_TABLES-1:0]       hupd;
		logic [NUM_TABLES-1:0][7:0]  haddr;
		logic [31:0]                 start;
		logic [31:0]                 sig;
		logic [7:0]                  n1;
		logic [7:0]                  n2;
		logic [7:0]                  n3;
	} win_t;

	typedef struct packed {
		logic        is_readout;
		logic [31:0] window_start;
		logic [31:0] signature;
		logic [63:0] read_value;
	} res_t;

	// lowest numbered matching base wins
	function automatic class_t classify(input logic [7:0] s, input cfg_t c);
		if (s == c.base1) return CL_B1;
		if (s == c.base2) return CL_B2;
		if (s == c.base3) return CL_B3;
		if (s == c.base4) return CL_B4;
		return CL_OTHER;
	endfunction

	function automatic logic [1:0] two_bit(input logic [7:0] s, input cfg_t c);
		if (s == c.base1) return 2'd0;
		if (s == c.base2) return 2'd1;
		if (s == c.base3) return 2'd2;
		return 2'd3;
	endfunction

endpackage

`default_nettype wire

/* rtl/window_base_count_signature_top.sv */
// ----------------------------------------------------------------------------
// window_base_count_signature_top
// Sliding window base counter with signatures, histograms and sums.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_*      | in        | tdata: symbol, entry_index; tuser: action, table_select
//  m_*      | out       | tdata: window_start, signature, read_value; tuser: is_readout
//  cfg_*    | in        | register index, 8-bit write data
//
// One request per cycle while the queue has room and no clearing pass runs.
// An accepted request reads the store, updates counts in the next cycle, does
// the histogram read-modify-write in the one after, and then queues its result for m_*.
// A four-entry output queue backs the pipeline; tready drops once four
// requests are in flight or queued, so output stalls never stop the pipe.
// After reset and after each restart a pass over all 256 entries zeroes the
// histograms; tready stays low from the restart's accept until the pass ends.
// Sums and total clear at once. The symbol store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module window_base_count_signature_top #(
	parameter int MAX_WINDOW = wbcs_pkg::MAX_WINDOW_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [15:0]  s_tdata,   // [7:0] symbol, [15:8] entry_index
	input  wire logic [3:0]   s_tuser,   // [1:0] action, [3:2] table_select
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [127:0]      m_tdata,   // [31:0] window_start, [63:32] signature,
	                                     // [127:64] read_value
	output logic [0:0]        m_tuser,   // [0] is_readout
	input  wire logic         cfg_wen,
	input  wire logic [2:0]   cfg_idx,
	input  wire logic [7:0]   cfg_wdata
);

	localparam int DEPTH = 4;

	wbcs_pkg::cfg_t cfg_q;
	wbcs_pkg::win_t win;
	wbcs_pkg::res_t res;
	wbcs_pkg::res_t fifo_q [DEPTH];
	logic           res_valid, no_res, acc, pop, busy, hold_q, rst_acc;
	logic [1:0]     wp_q, rp_q;
	logic [2:0]     cnt_q, occ_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base1 <= 8'd1;
			cfg_q.base2 <= 8'd2;
			cfg_q.base3 <= 8'd4;
			cfg_q.base4 <= 8'd8;
			cfg_q.wlen  <= 8'd16;
		end else if (cfg_wen) begin
			unique case (wbcs_pkg::reg_idx_t'(cfg_idx))
				wbcs_pkg::REG_BASE1: cfg_q.base1 <= cfg_wdata;
				wbcs_pkg::REG_BASE2: cfg_q.base2 <= cfg_wdata;
				wbcs_pkg::REG_BASE3: cfg_q.base3 <= cfg_wdata;
				wbcs_pkg::REG_BASE4: cfg_q.base4 <= cfg_wdata;
				wbcs_pkg::REG_WLEN:  cfg_q.wlen  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// hold off input from a restart until its clearing pass is done
	assign s_tready = (occ_q < 3'(DEPTH)) && !hold_q && !busy;
	assign acc      = s_tvalid && s_tready;
	assign rst_acc  = acc && (wbcs_pkg::action_t'(s_tuser[1:0]) == wbcs_pkg::ACT_RESTART);
	assign pop      = m_tvalid && m_tready;

	wbcs_window #(.MAX_WINDOW(MAX_WINDOW)) u_window (
		.clk   (clk),
		.arst_n(arst_n),
		.acc   (acc),
		.action(s_tuser[1:0]),
		.symbol(s_tdata[7:0]),
		.sel   (s_tuser[3:2]),
		.idx   (s_tdata[15:8]),
		.cfg   (cfg_q),
		.win   (win)
	);

	wbcs_stats u_stats (
		.clk      (clk),
		.arst_n   (arst_n),
		.win      (win),
		.res_valid(res_valid),
		.res      (res),
		.no_res   (no_res),
		.busy     (busy)
	);

	// occupancy: requests accepted whose results are not yet taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			cnt_q  <= '0;
			wp_q   <= '0;
			rp_q   <= '0;
			hold_q <= 1'b0;
		end else begin
			occ_q <= occ_q + 3'(acc) - 3'(pop) - 3'(no_res);
			cnt_q <= cnt_q + 3'(res_valid) - 3'(pop);
			if (res_valid) begin
				wp_q <= wp_q + 2'd1;
			end
			if (pop) begin
				rp_q <= rp_q + 2'd1;
			end
			priority if (rst_acc) begin
				hold_q <= 1'b1;
			end else if (busy) begin
				hold_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			fifo_q[wp_q] <= res;
		end
	end

	assign m_tvalid = cnt_q != 3'd0;
	assign m_tdata  = {fifo_q[rp_q].read_value, fifo_q[rp_q].signature,
		fifo_q[rp_q].window_start};
	assign m_tuser  = fifo_q[rp_q].is_readout;

`ifndef ASSERT_OFF
	a_occ_max: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= 3'(DEPTH))
		else $error("occupancy overflow");
	a_cnt_occ: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= occ_q)
		else $error("queue holds more than in flight");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !pop |-> cnt_q < 3'(DEPTH))
		else $error("result queue overflow");
`endif

endmodule

`default_nettype wire

/* rtl/wbcs_ram.sv */
// ----------------------------------------------------------------------------
// wbcs_ram
// Simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module wbcs_ram #(
	parameter int W  = 8,
	parameter int AW = 8
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem [2**AW];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* rtl/wbcs_window.sv */
// ----------------------------------------------------------------------------
// wbcs_window
// Symbol store, taint and position tracking, running counts and signature.
// ----------------------------------------------------------------------------
`default_nettype none

module wbcs_window #(
	parameter int MAX_WINDOW = wbcs_pkg::MAX_WINDOW_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  acc,
	input  wire logic [1:0]            action,
	input  wire logic [7:0]            symbol,
	input  wire logic [1:0]            sel,
	input  wire logic [7:0]            idx,
	input  wire wbcs_pkg::cfg_t        cfg,
	output wbcs_pkg::win_t             win
);

	localparam int NP = wbcs_pkg::STORE_PORTS;

	logic [7:0]  wr_ptr_q, taint_q;
	logic [31:0] seen_q;
	logic [7:0]  cnt1_q, cnt2_q, cnt3_q;

	logic [7:0]  len0, taint_eff;
	logic [31:0] lenm1;
	logic        push0, rst0, tainted0;
	wbcs_pkg::class_t cls0;
	logic [NP-1:0][7:0] rd_addr;
	logic [NP-1:0][7:0] rd_data;
	logic [NP-1:0][7:0] sy;

	logic              vld_s1, emit_s1, drop_s1, taint_s1;
	wbcs_pkg::action_t act_s1;
	wbcs_pkg::class_t  cls_s1;
	logic [1:0]        sel_s1;
	logic [7:0]        idx_s1, len_s1, sym_s1;
	logic [31:0]       start_s1;
	logic [NP-1:0]     fwd_s1;

	always_comb begin
		priority if (cfg.wlen < 8'd4) begin
			len0 = 8'd4;
		end else if (cfg.wlen > 8'(MAX_WINDOW)) begin
			len0 = 8'(MAX_WINDOW);
		end else begin
			len0 = cfg.wlen;
		end
	end

	assign push0     = acc && (wbcs_pkg::action_t'(action) == wbcs_pkg::ACT_PUSH);
	assign rst0      = acc && (wbcs_pkg::action_t'(action) == wbcs_pkg::ACT_RESTART);
	assign cls0      = wbcs_pkg::classify(symbol, cfg);
	assign taint_eff = (cls0 == wbcs_pkg::CL_OTHER) ? len0 : taint_q;
	assign tainted0  = taint_eff != 8'd0;
	assign lenm1     = {24'd0, len0 - 8'd1};

	// port 0: symbol leaving the window, ports 1..4: window prefix
	always_comb begin
		rd_addr[0] = wr_ptr_q - len0;
		for (int k = 1; k < NP; k++) begin
			rd_addr[k] = wr_ptr_q - len0 + 8'(k);
		end
	end

	for (genvar g = 0; g < NP; g++) begin : g_store
		wbcs_ram #(.W(8), .AW(8)) u_store (
			.clk  (clk),
			.we   (push0),
			.waddr(wr_ptr_q),
			.wdata(symbol),
			.raddr(rd_addr[g]),
			.rdata(rd_data[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			taint_q  <= '0;
			seen_q   <= '0;
			vld_s1   <= 1'b0;
		end else begin
			vld_s1 <= acc;
			if (rst0) begin
				wr_ptr_q <= '0;
				taint_q  <= '0;
				seen_q   <= '0;
			end else if (push0) begin
				wr_ptr_q <= wr_ptr_q + 8'd1;
				if (seen_q != wbcs_pkg::SAT32) begin
					seen_q <= seen_q + 32'd1;
				end
				taint_q <= tainted0 ? taint_eff - 8'd1 : 8'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		act_s1   <= wbcs_pkg::action_t'(action);
		sel_s1   <= sel;
		idx_s1   <= idx;
		cls_s1   <= cls0;
		emit_s1  <= seen_q >= lenm1;
		drop_s1  <= seen_q >= {24'd0, len0};
		taint_s1 <= tainted0;
		start_s1 <= seen_q - lenm1;
		len_s1   <= len0;
		sym_s1   <= symbol;
		for (int k = 0; k < NP; k++) begin
			fwd_s1[k] <= rd_addr[k] == wr_ptr_q;
		end
	end

	// stage 1: counts and signature
	logic [7:0]  n1, n2, n3;
	logic [10:0] h4;
	logic        push1, upd1;
	wbcs_pkg::class_t gone_cls;

	always_comb begin
		for (int k = 0; k < NP; k++) begin
			sy[k] = fwd_s1[k] ? sym_s1 : rd_data[k];
		end
	end

	assign push1    = vld_s1 && (act_s1 == wbcs_pkg::ACT_PUSH);
	assign upd1     = emit_s1 && !taint_s1;
	assign gone_cls = wbcs_pkg::classify(sy[0], cfg);

	always_comb begin
		n1 = cnt1_q;
		n2 = cnt2_q;
		n3 = cnt3_q;
		unique case (cls_s1)
			wbcs_pkg::CL_B1: n1 = n1 + 8'd1;
			wbcs_pkg::CL_B2: n2 = n2 + 8'd1;
			wbcs_pkg::CL_B3: n3 = n3 + 8'd1;
			wbcs_pkg::CL_B4: ;
			default: begin
				n1 = '0;
				n2 = '0;
				n3 = '0;
			end
		endcase
		if (upd1 && drop_s1) begin
			unique case (gone_cls)
				wbcs_pkg::CL_B1: n1 = n1 - 8'd1;
				wbcs_pkg::CL_B2: n2 = n2 - 8'd1;
				wbcs_pkg::CL_B3: n3 = n3 - 8'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt1_q <= '0;
			cnt2_q <= '0;
			cnt3_q <= '0;
		end else if (vld_s1 && act_s1 == wbcs_pkg::ACT_RESTART) begin
			cnt1_q <= '0;
			cnt2_q <= '0;
			cnt3_q <= '0;
		end else if (push1) begin
			cnt1_q <= n1;
			cnt2_q <= n2;
			cnt3_q <= n3;
		end
	end

	assign h4 = {3'd0, len_s1} - {3'd0, n1} - {3'd0, n2} - {3'd0, n3};

	always_comb begin
		win.valid    = vld_s1;
		win.action   = act_s1;
		win.sel      = sel_s1;
		win.idx      = idx_s1;
		win.emit     = emit_s1;
		win.upd      = upd1;
		win.haddr[0] = n1;
		win.haddr[1] = n2;
		win.haddr[2] = n3;
		win.haddr[3] = h4[7:0];
		win.hupd[0]  = n1 != 8'hFF;
		win.hupd[1]  = n2 != 8'hFF;
		win.hupd[2]  = n3 != 8'hFF;
		win.hupd[3]  = !h4[10] && (h4[9:0] < 10'(wbcs_pkg::HIST_DEPTH));
		win.start    = start_s1;
		win.sig      = taint_s1 ? wbcs_pkg::TAINT_SIG :
			{n1, n2, n3, wbcs_pkg::two_bit(sy[1], cfg), wbcs_pkg::two_bit(sy[2], cfg),
			 wbcs_pkg::two_bit(sy[3], cfg), wbcs_pkg::two_bit(sy[4], cfg)};
		win.n1       = n1;
		win.n2       = n2;
		win.n3       = n3;
	end

endmodule

`default_nettype wire

/* rtl/wbcs_stats.sv */
// ----------------------------------------------------------------------------
// wbcs_stats
// Histogram read-modify-write, count sums, window total and readouts.
// ----------------------------------------------------------------------------
`default_nettype none

module wbcs_stats (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire wbcs_pkg::win_t win,
	output logic                res_valid,
	output wbcs_pkg::res_t      res,
	output logic                no_res,
	output logic                busy
);

	localparam int NT = wbcs_pkg::NUM_TABLES;

	logic [NT-1:0][7:0]  addr1, addr_s2, laddr_q;
	logic [NT-1:0][31:0] hrd, cur, nxt, ldat_q;
	logic [NT-1:0]       wen, lwe_q;
	logic                lrst_q, vld_s2, push2, rst2, clr_q;
	logic [7:0]          caddr_q;
	wbcs_pkg::win_t      w_s2;
	logic [63:0]         sum1_q, sum2_q, sum3_q;
	logic [31:0]         total_q;

	always_comb begin
		for (int t = 0; t < NT; t++) begin
			addr1[t] = (win.action == wbcs_pkg::ACT_PUSH) ? win.haddr[t] : win.idx;
		end
	end

	// clearing pass owns the write port while it runs
	for (genvar g = 0; g < NT; g++) begin : g_hist
		wbcs_ram #(.W(32), .AW(8)) u_hist (
			.clk  (clk),
			.we   (wen[g] || clr_q),
			.waddr(clr_q ? caddr_q : addr_s2[g]),
			.wdata(clr_q ? 32'd0 : nxt[g]),
			.raddr(addr1[g]),
			.rdata(hrd[g])
		);
	end

	always_ff @(posedge clk) begin
		w_s2    <= win;
		addr_s2 <= addr1;
	end

	assign push2 = vld_s2 && (w_s2.action == wbcs_pkg::ACT_PUSH);
	assign rst2  = vld_s2 && (w_s2.action == wbcs_pkg::ACT_RESTART);
	assign busy  = clr_q;

	// forward the update written on the same edge as this read
	always_comb begin
		for (int t = 0; t < NT; t++) begin
			priority if (lrst_q) begin
				cur[t] = '0;
			end else if (lwe_q[t] && laddr_q[t] == addr_s2[t]) begin
				cur[t] = ldat_q[t];
			end else begin
				cur[t] = hrd[t];
			end
			nxt[t] = (cur[t] == wbcs_pkg::SAT32) ? cur[t] : cur[t] + 32'd1;
			wen[t] = push2 && w_s2.upd && w_s2.hupd[t];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			lrst_q  <= 1'b0;
			lwe_q   <= '0;
			sum1_q  <= '0;
			sum2_q  <= '0;
			sum3_q  <= '0;
			total_q <= '0;
			clr_q   <= 1'b1;
			caddr_q <= '0;
		end else begin
			vld_s2 <= win.valid;
			lrst_q <= rst2;
			lwe_q  <= wen;
			if (rst2) begin
				sum1_q  <= '0;
				sum2_q  <= '0;
				sum3_q  <= '0;
				total_q <= '0;
			end else if (push2 && w_s2.upd) begin
				sum1_q <= sum1_q + {56'd0, w_s2.n1};
				sum2_q <= sum2_q + {56'd0, w_s2.n2};
				sum3_q <= sum3_q + {56'd0, w_s2.n3};
				if (total_q != wbcs_pkg::SAT32) begin
					total_q <= total_q + 32'd1;
				end
			end
			// zeroing pass over all histogram entries
			if (rst2) begin
				clr_q   <= 1'b1;
				caddr_q <= '0;
			end else if (clr_q) begin
				caddr_q <= caddr_q + 8'd1;
				if (caddr_q == 8'hFF) begin
					clr_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		laddr_q <= addr_s2;
		ldat_q  <= nxt;
	end

	logic [63:0] rv;

	always_comb begin
		rv = '0;
		unique case (w_s2.action)
			wbcs_pkg::ACT_HIST: begin
				if (w_s2.idx != 8'hFF) begin
					rv = {32'd0, cur[w_s2.sel]};
				end
			end
			wbcs_pkg::ACT_SUM: begin
				unique case (w_s2.sel)
					2'd0: rv = sum1_q;
					2'd1: rv = sum2_q;
					2'd2: rv = sum3_q;
					default: rv = {32'd0, total_q};
				endcase
			end
			default: ;
		endcase
	end

	always_comb begin
		res_valid = vld_s2 && ((w_s2.action == wbcs_pkg::ACT_HIST) ||
			(w_s2.action == wbcs_pkg::ACT_SUM) || (push2 && w_s2.emit));
		no_res    = vld_s2 && !res_valid;
		res.is_readout   = !push2;
		res.window_start = push2 ? w_s2.start : 32'd0;
		res.signature    = push2 ? w_s2.sig : 32'd0;
		res.read_value   = rv;
	end

`ifndef ASSERT_OFF
	a_rst_total: assert property (@(posedge clk) disable iff (!arst_n)
		rst2 |=> (total_q == 32'd0) && (sum1_q == 64'd0))
		else $error("total not cleared by restart");
	a_fwd_rst: assert property (@(posedge clk) disable iff (!arst_n)
		lrst_q |-> (cur[0] == 32'd0) && (cur[3] == 32'd0))
		else $error("stale histogram after restart");
	a_wen_push: assert property (@(posedge clk) disable iff (!arst_n)
		(wen != '0) |-> push2 && !res.is_readout)
		else $error("histogram write without window");
	a_clr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !vld_s2)
		else $error("request reached histograms during clearing");
`endif

endmodule

`default_nettype wire
